/* hdl/rtph264_pkg.sv */
// Shared types and constants for the RTP H.264 FU-A packetizer.
// No dependencies; every other file of the block imports this package.
package rtph264_pkg;

  // Largest NAL unit accepted; longer lengths are clipped to this.
  localparam int unsigned MAX_NAL_BYTES = 262144;

  // Limits applied to the max_payload register.
  localparam logic [10:0] MIN_PAYLOAD = 11'd2;
  localparam logic [10:0] MAX_PAYLOAD = 11'd1486;

  // NAL unit type of an FU-A fragmentation unit.
  localparam logic [4:0] FU_A_TYPE = 5'd28;

  // First RTP header byte: version 2, no padding, no extension, no CSRC.
  localparam logic [7:0] RTP_BYTE0 = 8'h80;

  // Depth of the job queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
  localparam logic [1:0] REG_SSRC_ID = 2'd1;
  localparam logic [1:0] REG_TIMESTAMP_STEP = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  // One input transfer.
  typedef struct packed {
    logic [7:0]  nal_byte;
    logic        first_byte;
    logic [18:0] nal_length;
  } in_item_t;

  // One output transfer.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       start_of_packet;
    logic       end_of_packet;
    logic       last_of_run;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [6:0]  payload_type;
    logic [31:0] ssrc_id;
    logic [31:0] timestamp_step;
    logic [10:0] max_payload;
  } cfg_t;

  // Work for the back end, produced by one input byte.
  typedef struct packed {
    logic        hdr_en;    // emit the 12-byte RTP header
    logic        fu_en;     // emit FU indicator and FU header
    logic        data_en;   // emit the input byte itself
    logic        marker;
    logic        fu_start;
    logic        fu_end;
    logic        eop;       // end of packet on the final byte of the job
    logic [7:0]  nal_hdr;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  data;
  } job_t;

endpackage

/* hdl/rtph264_front.sv */
// Front end of the packetizer: tracks NAL and fragment state per input byte
// and turns each byte into a job for the back end. Depends on rtph264_pkg.
module rtph264_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  rtph264_pkg::in_item_t item_i,
  input  rtph264_pkg::cfg_t     cfg_i,
  output logic                  push_o,
  output rtph264_pkg::job_t     job_o
);
  import rtph264_pkg::*;

  logic [15:0] seq_q, seq_d;
  logic [31:0] ts_q, ts_d;
  logic [18:0] bln_q, bln_d;
  logic [10:0] blf_q, blf_d;
  logic        frag_q, frag_d;
  logic [7:0]  hdr_q, hdr_d;

  logic [10:0] mp;
  logic [18:0] len;
  logic [10:0] blf_tmp;
  logic        last;

  // Clip max_payload into its legal range.
  always_comb begin
    if (cfg_i.max_payload < MIN_PAYLOAD) begin
      mp = MIN_PAYLOAD;
    end else if (cfg_i.max_payload > MAX_PAYLOAD) begin
      mp = MAX_PAYLOAD;
    end else begin
      mp = cfg_i.max_payload;
    end
  end

  // Clip the NAL length into one to the largest NAL size.
  always_comb begin
    if (item_i.nal_length == 19'd0) begin
      len = 19'd1;
    end else if (item_i.nal_length > 19'(MAX_NAL_BYTES)) begin
      len = 19'(MAX_NAL_BYTES);
    end else begin
      len = item_i.nal_length;
    end
  end

  // Classify the byte and update the NAL state.
  always_comb begin
    seq_d   = seq_q;
    ts_d    = ts_q;
    bln_d   = bln_q;
    blf_d   = blf_q;
    frag_d  = frag_q;
    hdr_d   = hdr_q;
    push_o  = 1'b0;
    job_o   = '0;
    blf_tmp = blf_q;
    last    = 1'b0;
    if (accept_i) begin
      if (item_i.first_byte) begin
        // NAL header byte: always opens a new packet.
        ts_d  = ts_q + cfg_i.timestamp_step;
        seq_d = seq_q + 16'd1;
        hdr_d = item_i.nal_byte;
        bln_d = len - 19'd1;
        push_o        = 1'b1;
        job_o.hdr_en  = 1'b1;
        job_o.seq     = seq_d;
        job_o.ts      = ts_d;
        job_o.nal_hdr = item_i.nal_byte;
        job_o.data    = item_i.nal_byte;
        if (len <= {8'd0, mp}) begin
          frag_d        = 1'b0;
          blf_d         = 11'd0;
          job_o.data_en = 1'b1;
          job_o.eop     = (len == 19'd1);
        end else begin
          frag_d         = 1'b1;
          blf_d          = mp - 11'd1;
          job_o.fu_en    = 1'b1;
          job_o.fu_start = 1'b1;
        end
      end else if (bln_q != 19'd0) begin
        // Payload byte of an open NAL.
        push_o        = 1'b1;
        job_o.data_en = 1'b1;
        job_o.data    = item_i.nal_byte;
        job_o.nal_hdr = hdr_q;
        job_o.ts      = ts_q;
        job_o.seq     = seq_q;
        bln_d         = bln_q - 19'd1;
        if (frag_q) begin
          if (blf_q == 11'd0) begin
            // This byte opens the next fragment.
            last         = (bln_q <= {8'd0, mp});
            seq_d        = seq_q + 16'd1;
            job_o.hdr_en = 1'b1;
            job_o.fu_en  = 1'b1;
            job_o.marker = last;
            job_o.fu_end = last;
            job_o.seq    = seq_d;
            blf_tmp      = last ? bln_q[10:0] : mp;
          end
          blf_d     = blf_tmp - 11'd1;
          job_o.eop = (blf_d == 11'd0);
        end else begin
          job_o.eop = (bln_d == 19'd0);
        end
      end
    end
  end

  // NAL state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= '0;
      ts_q   <= '0;
      bln_q  <= '0;
      blf_q  <= '0;
      frag_q <= 1'b0;
      hdr_q  <= '0;
    end else begin
      seq_q  <= seq_d;
      ts_q   <= ts_d;
      bln_q  <= bln_d;
      blf_q  <= blf_d;
      frag_q <= frag_d;
      hdr_q  <= hdr_d;
    end
  end

endmodule

/* hdl/rtph264_queue.sv */
// Small job queue that decouples the front end from the back end.
// Depends on rtph264_pkg for the job type and depth.
module rtph264_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rtph264_pkg::job_t job_i,
  input  logic              pop_i,
  output rtph264_pkg::job_t job_o,
  output logic              full_o,
  output logic              empty_o
);
  import rtph264_pkg::*;

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d;
  logic [QUEUE_AW-1:0] rd_q, rd_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  // Pointer and count updates.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("job popped from an empty queue");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

endmodule

/* hdl/rtph264_back.sv */
// Back end of the packetizer: expands each job into packet bytes, one per cycle
// unless the output stalls, into a registered output stage. Depends on rtph264_pkg.
module rtph264_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rtph264_pkg::cfg_t      cfg_i,
  input  rtph264_pkg::job_t      job_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rtph264_pkg::out_item_t out_data_o
);
  import rtph264_pkg::*;

  // Byte slots of a job, in emission order.
  localparam logic [3:0] SLOT_VER    = 4'd0;
  localparam logic [3:0] SLOT_PT     = 4'd1;
  localparam logic [3:0] SLOT_SEQ_HI = 4'd2;
  localparam logic [3:0] SLOT_SEQ_LO = 4'd3;
  localparam logic [3:0] SLOT_TS_3   = 4'd4;
  localparam logic [3:0] SLOT_TS_2   = 4'd5;
  localparam logic [3:0] SLOT_TS_1   = 4'd6;
  localparam logic [3:0] SLOT_TS_0   = 4'd7;
  localparam logic [3:0] SLOT_SSRC_3 = 4'd8;
  localparam logic [3:0] SLOT_SSRC_2 = 4'd9;
  localparam logic [3:0] SLOT_SSRC_1 = 4'd10;
  localparam logic [3:0] SLOT_SSRC_0 = 4'd11;
  localparam logic [3:0] SLOT_FU_IND = 4'd12;
  localparam logic [3:0] SLOT_FU_HDR = 4'd13;
  localparam logic [3:0] SLOT_DATA   = 4'd14;

  logic        busy_q, busy_d;
  logic [3:0]  slot_q, slot_d;
  logic        valid_q, valid_d;
  out_item_t   data_q, data_d;

  logic [3:0]  slot;
  logic [3:0]  slot_nxt;
  logic        slot_last;
  logic        advance;
  logic [7:0]  byte_val;

  // Current slot: a fresh job starts at its first enabled slot.
  always_comb begin
    if (busy_q) begin
      slot = slot_q;
    end else if (job_i.hdr_en) begin
      slot = SLOT_VER;
    end else if (job_i.fu_en) begin
      slot = SLOT_FU_IND;
    end else begin
      slot = SLOT_DATA;
    end
  end

  // Following slot and end of job.
  always_comb begin
    slot_last = (slot == SLOT_DATA) || ((slot == SLOT_FU_HDR) && !job_i.data_en);
    if (slot == SLOT_SSRC_0) begin
      slot_nxt = job_i.fu_en ? SLOT_FU_IND : SLOT_DATA;
    end else begin
      slot_nxt = slot + 4'd1;
    end
  end

  // Byte for the current slot.
  always_comb begin
    unique case (slot)
      SLOT_VER:    byte_val = RTP_BYTE0;
      SLOT_PT:     byte_val = {job_i.marker, cfg_i.payload_type};
      SLOT_SEQ_HI: byte_val = job_i.seq[15:8];
      SLOT_SEQ_LO: byte_val = job_i.seq[7:0];
      SLOT_TS_3:   byte_val = job_i.ts[31:24];
      SLOT_TS_2:   byte_val = job_i.ts[23:16];
      SLOT_TS_1:   byte_val = job_i.ts[15:8];
      SLOT_TS_0:   byte_val = job_i.ts[7:0];
      SLOT_SSRC_3: byte_val = cfg_i.ssrc_id[31:24];
      SLOT_SSRC_2: byte_val = cfg_i.ssrc_id[23:16];
      SLOT_SSRC_1: byte_val = cfg_i.ssrc_id[15:8];
      SLOT_SSRC_0: byte_val = cfg_i.ssrc_id[7:0];
      SLOT_FU_IND: byte_val = {job_i.nal_hdr[7:5], FU_A_TYPE};
      SLOT_FU_HDR: byte_val = {job_i.fu_start, job_i.fu_end, 1'b0, job_i.nal_hdr[4:0]};
      SLOT_DATA:   byte_val = job_i.data;
      default:     byte_val = job_i.data;
    endcase
  end

  // Output register loads whenever a job is queued and the register is empty or its byte is taken.
  assign advance = !empty_i && (!valid_q || !out_stall_i);
  assign pop_o   = advance && slot_last;

  always_comb begin
    busy_d  = busy_q;
    slot_d  = slot_q;
    valid_d = valid_q;
    data_d  = data_q;
    if (advance) begin
      busy_d  = !slot_last;
      slot_d  = slot_nxt;
      valid_d = 1'b1;
      data_d.out_byte        = byte_val;
      data_d.start_of_packet = (slot == SLOT_VER);
      data_d.end_of_packet   = slot_last && job_i.eop;
      data_d.last_of_run     = slot_last;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      slot_q  <= SLOT_VER;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      slot_q  <= slot_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  a_busy_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !empty_i)
    else $error("back end mid-job with no job queued");

  a_sop_then_pt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && slot == SLOT_VER) |=> (busy_q && slot_q == SLOT_PT))
    else $error("header did not continue after its first byte");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (slot_q <= SLOT_DATA && slot_q != SLOT_VER))
    else $error("back end slot out of range");

endmodule

/* hdl/rtp_h264_fu_a_packetizer.sv */
// Top level of the RTP H.264 FU-A packetizer: configuration registers and
// the front, queue and back instances. Depends on rtph264_pkg and submodules.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one NAL byte
//   per transfer; the NAL header byte is flagged by first_byte and carries
//   the NAL length. Output channel (out_valid_o / out_stall_i / out_data_o)
//   delivers RTP packet bytes with start and end of packet flags, and
//   last_of_run on the final byte caused by each input byte.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//   must be issued only while the block is idle.
// Timing:
//   With the back end idle, the first output byte of an input transfer
//   passes through the job queue and then the output register. Payload
//   bytes inside a packet flow at one per cycle while out_stall_i is low.
//   A byte opening a packet yields 13 to 15 output bytes from the back end,
//   one per cycle unless stalled; the four-entry job queue holds later jobs and input stalls when it fills.
// Reset:
//   Registers return to payload type 96, SSRC 10, timestamp step 3600 and
//   max payload 1400; sequence number, timestamp and NAL state clear.
// Stall:
//   While out_stall_i is high the output byte holds; the queue keeps taking
//   input until it is full.
module rtp_h264_fu_a_packetizer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rtph264_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rtph264_pkg::out_item_t out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i
);
  import rtph264_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push, pop, full, empty, accept;
  job_t job_in, job_out;

  // Configuration register writes.
  assign cfg_ready_o = 1'b1;
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PAYLOAD_TYPE:   cfg_d.payload_type   = cfg_data_i[6:0];
        REG_SSRC_ID:        cfg_d.ssrc_id        = cfg_data_i;
        REG_TIMESTAMP_STEP: cfg_d.timestamp_step = cfg_data_i;
        REG_MAX_PAYLOAD:    cfg_d.max_payload    = cfg_data_i[10:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.payload_type   <= 7'd96;
      cfg_q.ssrc_id        <= 32'd10;
      cfg_q.timestamp_step <= 32'd3600;
      cfg_q.max_payload    <= 11'd1400;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input transfer completes when the queue has room.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  rtph264_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .cfg_i    (cfg_q),
    .push_o   (push),
    .job_o    (job_in)
  );

  rtph264_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .job_o   (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  rtph264_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (job_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
